### hw/rtl/gprs_pkg.sv
// shared types, constants and helpers for the gamepad report retransmit scheduler
package gprs_pkg;

    localparam int BTN_W   = 7;
    localparam int STICK_W = 8;
    localparam int SEQ_W   = 8;
    localparam int TICK_W  = 17;
    localparam int CFG_W   = 17;
    localparam int IDX_W   = 3;

    localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

    localparam int OUTQ_DEPTH = 4;
    localparam int OUTQ_PTR_W = $clog2(OUTQ_DEPTH);
    localparam int OUTQ_CNT_W = $clog2(OUTQ_DEPTH + 1);

    localparam logic [STICK_W-1:0] RST_DEAD_LOW    = 8'd105;
    localparam logic [STICK_W-1:0] RST_DEAD_HIGH   = 8'd125;
    localparam logic [STICK_W-1:0] RST_DEAD_CENTER = 8'd112;
    localparam logic [7:0]         RST_BURST_TICKS = 8'd3;
    localparam logic [TICK_W-1:0]  RST_MID_END     = 17'd2000;
    localparam logic [7:0]         RST_MID_PERIOD  = 8'd5;
    localparam logic [TICK_W-1:0]  RST_SLOW_END    = 17'd80000;
    localparam logic [7:0]         RST_SLOW_PERIOD = 8'd100;

    typedef enum logic [IDX_W-1:0] {
        REG_DEAD_LOW    = 3'd0,
        REG_DEAD_HIGH   = 3'd1,
        REG_DEAD_CENTER = 3'd2,
        REG_BURST_TICKS = 3'd3,
        REG_MID_END     = 3'd4,
        REG_MID_PERIOD  = 3'd5,
        REG_SLOW_END    = 3'd6,
        REG_SLOW_PERIOD = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [STICK_W-1:0] dead_low;
        logic [STICK_W-1:0] dead_high;
        logic [STICK_W-1:0] dead_center;
        logic [7:0]         burst_ticks;
        logic [TICK_W-1:0]  mid_end;
        logic [7:0]         mid_period;
        logic [TICK_W-1:0]  slow_end;
        logic [7:0]         slow_period;
    } t_cfg;

    typedef struct packed {
        logic [SEQ_W-1:0]   seq;
        logic [BTN_W-1:0]   buttons;
        logic [STICK_W-1:0] x;
        logic [STICK_W-1:0] y;
        logic               last;
    } t_report;

    typedef struct packed {
        logic    vld0;
        logic    vld1;
        t_report rep0;
        t_report rep1;
    } t_push;

    function automatic logic [STICK_W-1:0] snap_stick(input logic [STICK_W-1:0] v,
                                                      input t_cfg cfg);
        if (v > cfg.dead_low && v < cfg.dead_high) begin
            return cfg.dead_center;
        end
        return v;
    endfunction

    function automatic logic [TICK_W-1:0] tick_inc(input logic [TICK_W-1:0] v);
        if (v == TICK_MAX) begin
            return TICK_MAX;
        end
        return v + TICK_W'(1);
    endfunction

endpackage

### hw/rtl/gamepad_report_retransmit_scheduler_top.sv
// top level of the gamepad report retransmit scheduler
// an item is registered at acceptance; once the result queue has room its reports are
// written into the queue, and the first is offered once earlier reports have been taken
// throughput: one item per cycle while the result queue has room for two reports;
// the output side hands out one report per cycle while i_out_stall is low; synchronous
// active-low reset restores register defaults and clears flags, pointers, counts and history
module gamepad_report_retransmit_scheduler_top (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [gprs_pkg::IDX_W-1:0]   i_cfg_index,
    input  logic [gprs_pkg::CFG_W-1:0]   i_cfg_data,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [gprs_pkg::BTN_W-1:0]   i_pressed_buttons,
    input  logic [gprs_pkg::STICK_W-1:0] i_stick_x,
    input  logic [gprs_pkg::STICK_W-1:0] i_stick_y,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic [gprs_pkg::SEQ_W-1:0]   o_seq_byte,
    output logic [gprs_pkg::BTN_W-1:0]   o_buttons_out,
    output logic [gprs_pkg::STICK_W-1:0] o_x_out,
    output logic [gprs_pkg::STICK_W-1:0] o_y_out,
    output logic                         o_last
);
    import gprs_pkg::*;

    t_cfg    cfg;
    t_push   push;
    t_report rep;
    logic    room;

    gprs_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    gprs_core u_core (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg             (cfg),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_pressed_buttons (i_pressed_buttons),
        .i_stick_x         (i_stick_x),
        .i_stick_y         (i_stick_y),
        .i_room            (room),
        .o_push            (push)
    );

    gprs_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .o_room      (room),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_rep       (rep)
    );

    assign o_seq_byte    = rep.seq;
    assign o_buttons_out = rep.buttons;
    assign o_x_out       = rep.x;
    assign o_y_out       = rep.y;
    assign o_last        = rep.last;

endmodule

### hw/rtl/gprs_cfg.sv
// configuration register file
module gprs_cfg (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_cfg_we,
    input  logic [gprs_pkg::IDX_W-1:0] i_cfg_index,
    input  logic [gprs_pkg::CFG_W-1:0] i_cfg_data,
    output gprs_pkg::t_cfg             o_cfg
);
    import gprs_pkg::*;

    t_cfg r_cfg;
    t_cfg n_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_DEAD_LOW:    n_cfg.dead_low    = i_cfg_data[STICK_W-1:0];
                REG_DEAD_HIGH:   n_cfg.dead_high   = i_cfg_data[STICK_W-1:0];
                REG_DEAD_CENTER: n_cfg.dead_center = i_cfg_data[STICK_W-1:0];
                REG_BURST_TICKS: n_cfg.burst_ticks = i_cfg_data[7:0];
                REG_MID_END:     n_cfg.mid_end     = i_cfg_data[TICK_W-1:0];
                REG_MID_PERIOD:  n_cfg.mid_period  = i_cfg_data[7:0];
                REG_SLOW_END:    n_cfg.slow_end    = i_cfg_data[TICK_W-1:0];
                REG_SLOW_PERIOD: n_cfg.slow_period = i_cfg_data[7:0];
                default:         n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dead_low    <= RST_DEAD_LOW;
            r_cfg.dead_high   <= RST_DEAD_HIGH;
            r_cfg.dead_center <= RST_DEAD_CENTER;
            r_cfg.burst_ticks <= RST_BURST_TICKS;
            r_cfg.mid_end     <= RST_MID_END;
            r_cfg.mid_period  <= RST_MID_PERIOD;
            r_cfg.slow_end    <= RST_SLOW_END;
            r_cfg.slow_period <= RST_SLOW_PERIOD;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

### hw/rtl/gprs_core.sv
// input register, dead zone, change detection and retransmit decision
module gprs_core (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gprs_pkg::t_cfg               i_cfg,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic [gprs_pkg::BTN_W-1:0]   i_pressed_buttons,
    input  logic [gprs_pkg::STICK_W-1:0] i_stick_x,
    input  logic [gprs_pkg::STICK_W-1:0] i_stick_y,
    input  logic                         i_room,
    output gprs_pkg::t_push              o_push
);
    import gprs_pkg::*;

    logic               r_in_valid, n_in_valid;
    logic [BTN_W-1:0]   r_in_buttons;
    logic [STICK_W-1:0] r_in_x, r_in_y;

    logic [BTN_W-1:0]   r_prev_buttons, n_prev_buttons;
    logic [STICK_W-1:0] r_prev_x, n_prev_x, r_prev_y, n_prev_y;
    logic [SEQ_W-1:0]   r_change_count, n_change_count;
    logic [SEQ_W-1:0]   r_current_seq, n_current_seq;
    logic [TICK_W-1:0]  r_ts, n_ts, r_tc, n_tc;

    logic               accept, proc, changed, resend;
    logic [STICK_W-1:0] sx, sy;
    logic [TICK_W-1:0]  ts1, tc1;
    t_report            rep_new, rep_re;

    assign accept     = i_in_valid && !o_in_stall;
    assign proc       = r_in_valid && i_room;
    assign o_in_stall = r_in_valid && !i_room;
    assign n_in_valid = accept || (r_in_valid && !proc);

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_in_buttons <= i_pressed_buttons;
            r_in_x       <= i_stick_x;
            r_in_y       <= i_stick_y;
        end
    end

    always_comb begin
        sx      = snap_stick(r_in_x, i_cfg);
        sy      = snap_stick(r_in_y, i_cfg);
        changed = (r_in_buttons != r_prev_buttons) || (sx != r_prev_x) || (sy != r_prev_y);
        n_change_count = changed ? r_change_count + SEQ_W'(1) : r_change_count;
        ts1 = tick_inc(changed ? '0 : r_ts);
        tc1 = tick_inc(changed ? '0 : r_tc);
        if (tc1 <= TICK_W'(i_cfg.burst_ticks)) begin
            resend = (ts1 == TICK_W'(1));
        end else if (tc1 < i_cfg.mid_end) begin
            resend = (ts1 == TICK_W'(i_cfg.mid_period));
        end else if (tc1 < i_cfg.slow_end) begin
            resend = (ts1 == TICK_W'(i_cfg.slow_period));
        end else begin
            resend = 1'b0;
        end

        rep_new = '{seq: r_current_seq, buttons: r_in_buttons, x: sx, y: sy, last: !resend};
        rep_re  = '{seq: n_change_count, buttons: r_in_buttons, x: sx, y: sy, last: 1'b1};

        o_push.vld0 = proc && (changed || resend);
        o_push.vld1 = proc && changed && resend;
        o_push.rep0 = changed ? rep_new : rep_re;
        o_push.rep1 = rep_re;

        n_prev_buttons = r_in_buttons;
        n_prev_x       = sx;
        n_prev_y       = sy;
        n_current_seq  = n_change_count;
        n_ts           = resend ? '0 : ts1;
        n_tc           = tc1;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid     <= 1'b0;
            r_prev_buttons <= '0;
            r_prev_x       <= '0;
            r_prev_y       <= '0;
            r_change_count <= '0;
            r_current_seq  <= '0;
            r_ts           <= '0;
            r_tc           <= '0;
        end else begin
            r_in_valid <= n_in_valid;
            if (proc) begin
                r_prev_buttons <= n_prev_buttons;
                r_prev_x       <= n_prev_x;
                r_prev_y       <= n_prev_y;
                r_change_count <= n_change_count;
                r_current_seq  <= n_current_seq;
                r_ts           <= n_ts;
                r_tc           <= n_tc;
            end
        end
    end

endmodule

### hw/rtl/gprs_outq.sv
// result queue, takes up to two reports per cycle and hands out one when not stalled
module gprs_outq (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  gprs_pkg::t_push              i_push,
    output logic                         o_room,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output gprs_pkg::t_report            o_rep
);
    import gprs_pkg::*;

    t_report               r_mem [OUTQ_DEPTH];
    logic [OUTQ_PTR_W-1:0] r_wptr, n_wptr, r_rptr, n_rptr;
    logic [OUTQ_CNT_W-1:0] r_count, n_count;
    logic                  pop;
    logic [1:0]            push_cnt;
    logic [OUTQ_PTR_W-1:0] wptr1;

    assign o_room      = r_count <= OUTQ_CNT_W'(OUTQ_DEPTH - 2);
    assign o_out_valid = r_count != '0;
    assign pop         = o_out_valid && !i_out_stall;
    assign o_rep       = r_mem[r_rptr];
    assign wptr1       = r_wptr + OUTQ_PTR_W'(1);

    always_comb begin
        push_cnt = 2'(i_push.vld0) + 2'(i_push.vld1);
        n_wptr   = r_wptr + OUTQ_PTR_W'(push_cnt);
        n_rptr   = r_rptr + OUTQ_PTR_W'(pop);
        n_count  = r_count + OUTQ_CNT_W'(push_cnt) - OUTQ_CNT_W'(pop);
    end

    always_ff @(posedge i_clk) begin
        if (i_push.vld0) begin
            r_mem[r_wptr] <= i_push.rep0;
        end
        if (i_push.vld1) begin
            r_mem[wptr1] <= i_push.rep1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= OUTQ_CNT_W'(OUTQ_DEPTH))
        else $error("result queue overfilled");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.vld1 |-> (i_push.vld0 && !i_push.rep0.last && i_push.rep1.last))
        else $error("second report pushed without a leading first one");

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push.vld0 |-> $past(o_room) || r_count <= OUTQ_CNT_W'(OUTQ_DEPTH - 2))
        else $error("report pushed without room");

    a_pop_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !i_push.vld0) |=> r_count == $past(r_count) - OUTQ_CNT_W'(1))
        else $error("queue count lost track of a pop");

endmodule
